>>> rtl/hrhsv_pkg.sv
// Shared types and constants for the hue rotating HSV color core.
`default_nettype none

package hrhsv_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WRAP,
    ST_SECT,
    ST_LOAD,
    ST_MUL1,
    ST_MUL2,
    ST_DIV,
    ST_OUT
  } st_t;

  typedef enum logic [1:0] {
    COMP_P,
    COMP_Q,
    COMP_T
  } comp_t;

  localparam logic        MODE_LOAD = 1'b0;
  localparam logic signed [14:0] TURN = 15'sd5760;
  localparam logic [12:0] SECTOR = 13'd960;
  localparam logic [17:0] QDEN   = 18'd244800;
  localparam logic [18:0] QDEN2  = 19'd489600;

endpackage

`default_nettype wire

>>> rtl/hue_rotating_hsv_color_core.sv
// Hue rotating HSV color source with a bit-serial HSV to RGB converter.
//
// Input stream (s_*): one transaction either loads hue, saturation and value
// (s_tuser = 0) or adds a signed hue step to the held hue (s_tuser = 1).
// Output stream (m_*): one transaction per input transaction carrying the
// rounded 8-bit red, green and blue of the color after the update.
//
// An accepted input first has its hue wrapped into one turn, then its sector
// found; then each of p, q and t goes through one shared shift-add multiplier
// (sat * m, then val * (244800 - sat * m)) and one restoring divider (one
// quotient bit per step). One item is in flight at a time, so the block takes
// no new input until the last result has entered the output register.
//
// Reset clears the held color to hue 0, saturation 0, value 0 (black) and
// empties the output register. A stalled receiver holds the result in the
// output register; the next input is taken meanwhile and its result waits
// until the output register drains.
`default_nettype none

module hue_rotating_hsv_color_core
  import hrhsv_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // hue_in[12:0], sat_in[20:13], val_in[28:21], hue_step[42:29], zeros[47:43]
  input  wire logic [47:0] s_tdata,
  // mode[0]
  input  wire logic        s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // red[7:0], green[15:8], blue[23:16]
  output logic [23:0]      m_tdata
);

  st_t state, state_next;

  logic [12:0]        hue;
  logic [7:0]         sat;
  logic [7:0]         val;
  logic signed [14:0] acc;
  logic [12:0]        hue_rem;
  logic [2:0]         sector;
  comp_t              comp;
  logic [2:0]         step;
  logic [25:0]        mcand;
  logic [25:0]        prod;
  logic [7:0]         mplier;
  logic [18:0]        rem;
  logic [7:0]         nlow;
  logic [7:0]         quo;
  logic [7:0]         p_val;
  logic [7:0]         q_val;
  logic [7:0]         t_val;

  logic        accept;
  logic        acc_lo;
  logic        acc_hi;
  logic        sect_ge;
  logic [9:0]  frac;
  logic [9:0]  m_sel;
  logic [25:0] prod_add;
  logic [17:0] a_diff;
  logic [26:0] num;
  logic [19:0] r2;
  logic        r_ge;
  logic [19:0] r_sub;
  logic        last;
  logic        out_free;

  logic        in_mode;
  logic [12:0] in_hue;
  logic [7:0]  in_sat;
  logic [7:0]  in_val;
  logic [13:0] in_step;

  assign in_mode = s_tuser;
  assign in_hue  = s_tdata[12:0];
  assign in_sat  = s_tdata[20:13];
  assign in_val  = s_tdata[28:21];
  assign in_step = s_tdata[42:29];

  assign accept   = s_tvalid && s_tready;
  assign acc_lo   = acc[14];
  assign acc_hi   = !acc[14] && (acc >= TURN);
  assign sect_ge  = hue_rem >= SECTOR;
  assign frac     = hue_rem[9:0];
  assign last     = step == 3'd7;
  assign out_free = !m_tvalid || m_tready;

  // p uses m = 960, q uses m = frac, t uses m = 960 - frac
  always_comb begin
    case (comp)
      COMP_P:  m_sel = SECTOR[9:0];
      COMP_Q:  m_sel = frac;
      default: m_sel = SECTOR[9:0] - frac;
    endcase
  end

  assign prod_add = prod + (mplier[0] ? mcand : 26'd0);
  assign a_diff   = QDEN - prod_add[17:0];
  // rounding numerator 2n + d over divisor 2d
  assign num      = {prod_add, 1'b0} + {9'd0, QDEN};
  assign r2       = {rem, nlow[7]};
  assign r_ge     = r2 >= {1'b0, QDEN2};
  assign r_sub    = r2 - {1'b0, QDEN2};

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (accept) state_next = ST_WRAP;
      ST_WRAP: if (!acc_lo && !acc_hi) state_next = ST_SECT;
      ST_SECT: if (!sect_ge) state_next = ST_LOAD;
      ST_LOAD: state_next = ST_MUL1;
      ST_MUL1: if (last) state_next = ST_MUL2;
      ST_MUL2: if (last) state_next = ST_DIV;
      ST_DIV:  if (last) state_next = (comp == COMP_T) ? ST_OUT : ST_LOAD;
      ST_OUT:  if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    case (state)
      ST_IDLE: s_tready = 1'b1;
      default: s_tready = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
      hue      <= '0;
      sat      <= '0;
      val      <= '0;
      comp     <= COMP_P;
      step     <= '0;
    end else begin
      state <= state_next;
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            if (in_mode == MODE_LOAD) begin
              acc <= $signed({2'b00, in_hue});
              sat <= in_sat;
              val <= in_val;
            end else begin
              acc <= $signed({2'b00, hue}) + $signed({in_step[13], in_step});
            end
          end
        end
        ST_WRAP: begin
          if (acc_lo) begin
            acc <= acc + TURN;
          end else if (acc_hi) begin
            acc <= acc - TURN;
          end else begin
            hue     <= acc[12:0];
            hue_rem <= acc[12:0];
            sector  <= 3'd0;
            comp    <= COMP_P;
          end
        end
        ST_SECT: begin
          if (sect_ge) begin
            hue_rem <= hue_rem - SECTOR;
            sector  <= sector + 3'd1;
          end
        end
        ST_LOAD: begin
          mcand  <= {16'd0, m_sel};
          mplier <= sat;
          prod   <= '0;
          step   <= '0;
        end
        ST_MUL1: begin
          step <= step + 3'd1;
          if (last) begin
            mcand  <= {8'd0, a_diff};
            mplier <= val;
            prod   <= '0;
          end else begin
            prod   <= prod_add;
            mcand  <= {mcand[24:0], 1'b0};
            mplier <= {1'b0, mplier[7:1]};
          end
        end
        ST_MUL2: begin
          prod   <= prod_add;
          mcand  <= {mcand[24:0], 1'b0};
          mplier <= {1'b0, mplier[7:1]};
          step   <= step + 3'd1;
          if (last) begin
            rem  <= num[26:8];
            nlow <= num[7:0];
            quo  <= '0;
          end
        end
        ST_DIV: begin
          rem  <= r_ge ? r_sub[18:0] : r2[18:0];
          nlow <= {nlow[6:0], 1'b0};
          quo  <= {quo[6:0], r_ge};
          step <= step + 3'd1;
          if (last) begin
            case (comp)
              COMP_P:  p_val <= {quo[6:0], r_ge};
              COMP_Q:  q_val <= {quo[6:0], r_ge};
              default: t_val <= {quo[6:0], r_ge};
            endcase
            case (comp)
              COMP_P:  comp <= COMP_Q;
              default: comp <= COMP_T;
            endcase
          end
        end
        ST_OUT: begin
          if (out_free) begin
            case (sector)
              3'd0:    m_tdata <= {p_val, t_val, val};
              3'd1:    m_tdata <= {p_val, val, q_val};
              3'd2:    m_tdata <= {t_val, val, p_val};
              3'd3:    m_tdata <= {val, q_val, p_val};
              3'd4:    m_tdata <= {val, p_val, t_val};
              default: m_tdata <= {q_val, p_val, val};
            endcase
          end
        end
        default: ;
      endcase
    end
  end

  a_hue_in_turn: assert property (@(posedge clk) disable iff (rst)
    hue < TURN[12:0])
    else $error("held hue outside one turn");

  a_accept_starts_wrap: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_WRAP)
    else $error("accepted transaction did not start hue wrap");

  a_sector_ready: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> (sector <= 3'd5) && (hue_rem < SECTOR))
    else $error("sector search left hue remainder out of range");

  a_div_rem_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_DIV |-> rem < QDEN2)
    else $error("divider remainder not below divisor");

  a_out_only_after_div: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(state) == ST_OUT)
    else $error("result presented outside the output step");

endmodule

`default_nettype wire

>>> tb/tb_hue_rotating_hsv_color_core.sv
// Self-checking testbench for the hue rotating HSV color core.
`timescale 1ns / 100ps

module tb_hue_rotating_hsv_color_core;

  localparam logic MODE_STEP = 1'b1;
  localparam int TURN_UNITS = 5760;
  localparam int SECTOR_UNITS = 960;
  localparam longint FULL_SCALE = 255;
  localparam longint FRAC_SCALE = FULL_SCALE * SECTOR_UNITS;
  localparam int DRAIN_CYCLES = 120;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;

  // held color as the core should see it
  logic [12:0] color_hue;
  logic [7:0]  color_sat;
  logic [7:0]  color_val;

  rgb_t pending_rgb[$];
  int   error_count = 0;
  bit   no_idle = 1'b0;

  hue_rotating_hsv_color_core dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [7:0] round_scaled(longint num, longint den);
    longint r;
    r = (2 * num + den) / (2 * den);
    return (r > FULL_SCALE) ? 8'd255 : r[7:0];
  endfunction

  function automatic rgb_t hsv_to_rgb(logic [12:0] h, logic [7:0] s, logic [7:0] v);
    int   sector;
    int   frac;
    logic [7:0] p, q, t;
    rgb_t c;
    if (s == 0) begin
      c = '{v, v, v};
    end else begin
      sector = h / SECTOR_UNITS;
      frac   = h % SECTOR_UNITS;
      p = round_scaled(longint'(v) * (FULL_SCALE - s), FULL_SCALE);
      q = round_scaled(longint'(v) * (FRAC_SCALE - longint'(s) * frac), FRAC_SCALE);
      t = round_scaled(longint'(v) * (FRAC_SCALE - longint'(s) * (SECTOR_UNITS - frac)),
                       FRAC_SCALE);
      case (sector)
        0: c = '{v, t, p};
        1: c = '{q, v, p};
        2: c = '{p, v, t};
        3: c = '{p, q, v};
        4: c = '{t, p, v};
        default: c = '{v, p, q};
      endcase
    end
    return c;
  endfunction

  // Update the held color for one accepted transaction and return its color.
  function automatic rgb_t update_color(logic mode, logic [12:0] h, logic [7:0] s,
                                        logic [7:0] v, logic signed [13:0] stp);
    int sum;
    if (mode == hrhsv_pkg::MODE_LOAD) begin
      color_hue = 13'(int'(h) % TURN_UNITS);
      color_sat = s;
      color_val = v;
    end else begin
      sum = (int'(color_hue) + int'(stp)) % TURN_UNITS;
      if (sum < 0) sum += TURN_UNITS;
      color_hue = 13'(sum);
    end
    return hsv_to_rgb(color_hue, color_sat, color_val);
  endfunction

  // Mostly short idle stretches, now and then a long one.
  function automatic int idle_len();
    int pick;
    if (no_idle) return 0;
    pick = $urandom_range(99);
    if (pick < 65) return 0;
    if (pick < 90) return $urandom_range(4, 1);
    return $urandom_range(150, 10);
  endfunction

  task automatic send_item(input logic mode, input logic [12:0] h, input logic [7:0] s,
                           input logic [7:0] v, input logic signed [13:0] stp);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= mode;
    s_tdata  <= {5'b0, stp, v, s, h};
    do @(posedge clk); while (!s_tready);
    pending_rgb.push_back(update_color(mode, h, s, v, stp));
  endtask

  task automatic load_hsv(input logic [12:0] h, input logic [7:0] s, input logic [7:0] v);
    send_item(hrhsv_pkg::MODE_LOAD, h, s, v, 14'($urandom));
  endtask

  task automatic step_hue(input logic signed [13:0] stp);
    send_item(MODE_STEP, 13'($urandom), 8'($urandom), 8'($urandom), stp);
  endtask

  // receiver: runs of ready broken by random stalls
  initial begin
    int n;
    wait (!rst);
    forever begin
      n = no_idle ? 50 : $urandom_range(($urandom_range(3) == 0) ? 400 : 8, 1);
      m_tready <= 1'b1;
      repeat (n) @(posedge clk);
      n = idle_len();
      if (n > 0) begin
        m_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    rgb_t want;
    rgb_t got;
    if (!rst && m_tvalid && m_tready) begin
      // red sits in the low byte of m_tdata
      got = rgb_t'({m_tdata[7:0], m_tdata[15:8], m_tdata[23:16]});
      if (pending_rgb.size() == 0) begin
        $error("unexpected output transaction: %h", m_tdata);
        error_count++;
      end else begin
        want = pending_rgb.pop_front();
        if (got.red !== want.red) begin
          $error("red: expected %0d, actual %0d", want.red, got.red);
          error_count++;
        end
        if (got.green !== want.green) begin
          $error("green: expected %0d, actual %0d", want.green, got.green);
          error_count++;
        end
        if (got.blue !== want.blue) begin
          $error("blue: expected %0d, actual %0d", want.blue, got.blue);
          error_count++;
        end
      end
    end
  end

  // A reset color is black; a negative step from hue 0 wraps to the top.
  task automatic test_reset_state();
    step_hue(14'sd0);
    step_hue(-14'sd1);
  endtask

  task automatic test_grey();
    load_hsv(13'd1234, 8'd0, 8'd255);
    load_hsv(13'd8191, 8'd0, 8'd0);
    load_hsv(13'd3000, 8'd0, 8'd77);
  endtask

  task automatic test_sectors();
    load_hsv(13'd0, 8'd255, 8'd255);
    repeat (5) step_hue(14'sd960);
    load_hsv(13'd959, 8'd128, 8'd200);
    load_hsv(13'd5759, 8'd255, 8'd1);
  endtask

  task automatic test_wrap();
    load_hsv(13'd5760, 8'd200, 8'd255);
    step_hue(14'sd5759);
    step_hue(-14'sd5759);
    step_hue(14'sd8191);
    step_hue(-14'sd8192);
    load_hsv(13'd100, 8'd1, 8'd255);
    step_hue(-14'sd101);
  endtask

  function automatic logic [7:0] pick_level();
    int pick;
    pick = $urandom_range(9);
    if (pick == 0) return 8'd0;
    if (pick == 1) return 8'd255;
    return 8'($urandom);
  endfunction

  task automatic test_random(input int count);
    logic [12:0] h;
    int stp;
    for (int i = 0; i < count; i++) begin
      // open with a burst that never idles
      no_idle = (i < 150);
      if ($urandom_range(1) == 0) begin
        h = ($urandom_range(99) < 85) ? 13'($urandom_range(TURN_UNITS - 1))
                                      : 13'($urandom_range(8191, TURN_UNITS));
        load_hsv(h, pick_level(), pick_level());
      end else begin
        if ($urandom_range(99) < 85)
          stp = int'($urandom_range(2 * (TURN_UNITS - 1))) - (TURN_UNITS - 1);
        else
          stp = int'($urandom_range(16383)) - 8192;
        step_hue(14'(stp));
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    color_hue = '0;
    color_sat = '0;
    color_val = '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_reset_state();
    test_grey();
    test_sectors();
    test_wrap();
    test_random(650);
    s_tvalid <= 1'b0;
    while (pending_rgb.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> hue_rotating_hsv_color_core.f
rtl/hrhsv_pkg.sv
rtl/hue_rotating_hsv_color_core.sv
tb/tb_hue_rotating_hsv_color_core.sv
